// File: sv/lpht_pkg.sv
// Shared types and constants of the linear probing hash table.
package lpht_pkg;

    localparam int CMD_W         = 2;
    localparam int KEY_W         = 31;
    localparam int SIZE_W        = 7;
    localparam int SLOT_W        = 6;
    localparam int DEPTH_DEF     = 64;
    localparam int SIZE_MAX      = 127;
    localparam int DIV_STEPS     = (KEY_W + 1) / 2;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    typedef struct packed {
        logic              start;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
    } t_mod_req;

    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] rem;
    } t_mod_rsp;

endpackage

// File: sv/lpht_if.sv
// Command and result channel interfaces of the linear probing hash table.
interface lpht_cmd_if;
    logic                      valid;
    logic                      ready;
    logic [lpht_pkg::CMD_W-1:0] command;
    logic [lpht_pkg::KEY_W-1:0] key;

    modport source (output valid, output command, output key, input ready);
    modport sink   (input valid, input command, input key, output ready);
endinterface

interface lpht_res_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic [lpht_pkg::SLOT_W-1:0] slot_index;

    modport source (output valid, output status, output slot_index, input ready);
    modport sink   (input valid, input status, input slot_index, output ready);
endinterface

// File: sv/lpht_mod.sv
// Iterative key modulo table size unit, two remainder bits a cycle.
module lpht_mod (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lpht_pkg::t_mod_req i_req,
    output lpht_pkg::t_mod_rsp o_rsp
);

    logic                               r_busy;
    logic                               r_done;
    logic [lpht_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [lpht_pkg::KEY_W:0]           r_kq;
    logic [lpht_pkg::SIZE_W-1:0]        r_rem;
    logic [lpht_pkg::SIZE_W-1:0]        r_size;
    logic [lpht_pkg::SIZE_W:0]          t1;
    logic [lpht_pkg::SIZE_W:0]          t2;
    logic [lpht_pkg::SIZE_W-1:0]        n_rem;

    always_comb begin
        t1 = {r_rem, r_kq[lpht_pkg::KEY_W]};
        if (t1 >= {1'b0, r_size}) begin
            t1 = t1 - {1'b0, r_size};
        end
        t2 = {t1[lpht_pkg::SIZE_W-1:0], r_kq[lpht_pkg::KEY_W-1]};
        if (t2 >= {1'b0, r_size}) begin
            t2 = t2 - {1'b0, r_size};
        end
        n_rem = t2[lpht_pkg::SIZE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == lpht_pkg::DIV_CNT_W'(lpht_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_kq   <= {1'b0, i_req.key};
            r_rem  <= '0;
            r_size <= i_req.size;
        end else if (r_busy) begin
            r_kq  <= {r_kq[lpht_pkg::KEY_W-2:0], 2'b00};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// File: sv/linear_probe_hash_table.sv
// Linear probing hash table of non-negative keys: sequencer, key store and valid marks.
//
// A command word (insert, delete or search plus a 31-bit key) is taken on i_cmd when the
// table is idle; each word gives exactly one result word (status, slot_index) on o_res.
// The home slot is key modulo the live table size, found by the remainder unit. Probing
// then reads one slot a cycle from the key memory, whose registered read data is compared
// in the next cycle; i_cmd is not ready from acceptance until the result is written back.
// The result sits in an output register; while the receiver stalls, the next command is
// still accepted and worked on, and only its write-back waits until o_res is free.
// i_cfg_we writes table_size (0 acts as 1, above TABLE_DEPTH acts as TABLE_DEPTH); write
// it only when the table is idle. Synchronous reset empties every slot, sets table_size
// to 64 and drops any pending result; no clearing pass is needed.
module linear_probe_hash_table #(
    parameter int TABLE_DEPTH = lpht_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lpht_cmd_if.sink                      i_cmd,
    lpht_res_if.source                    o_res,
    input  logic                          i_cfg_we,
    input  logic [lpht_pkg::SIZE_W-1:0]   i_cfg_wdata
);

    localparam int NSLOT = (TABLE_DEPTH < lpht_pkg::SIZE_MAX) ? TABLE_DEPTH
                                                              : lpht_pkg::SIZE_MAX;
    localparam int IW    = $clog2(NSLOT);
    localparam logic [lpht_pkg::SIZE_W-1:0] NSLOT_S = lpht_pkg::SIZE_W'(NSLOT);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                     r_state;
    logic [lpht_pkg::SIZE_W-1:0]    r_table_size;
    logic [lpht_pkg::CMD_W-1:0]     r_cmd;
    logic [lpht_pkg::KEY_W-1:0]     r_key;
    logic [lpht_pkg::SIZE_W-1:0]    r_size;
    logic [IW-1:0]                  r_pos;
    logic [lpht_pkg::SIZE_W-1:0]    r_issued;
    logic                           r_chk_valid;
    logic                           r_chk_used;
    logic [IW-1:0]                  r_chk_pos;
    logic                           r_ok;
    logic [IW-1:0]                  r_res_pos;
    logic [NSLOT-1:0]               r_used;
    logic [lpht_pkg::KEY_W-1:0]     r_mem [NSLOT];
    logic [lpht_pkg::KEY_W-1:0]     r_rd;
    logic                           r_out_valid;
    logic                           r_out_status;
    logic [lpht_pkg::SLOT_W-1:0]    r_out_slot;

    logic [lpht_pkg::SIZE_W-1:0]    live_size;
    logic                           accept;
    logic                           hit;
    logic                           issue;
    logic                           retire;
    logic [IW-1:0]                  n_pos;
    logic [7:0]                     res_pos8;
    lpht_pkg::t_mod_req             mod_req;
    lpht_pkg::t_mod_rsp             mod_rsp;

    assign accept = i_cmd.valid && i_cmd.ready;

    always_comb begin
        if (r_table_size == '0) begin
            live_size = lpht_pkg::SIZE_W'(1);
        end else if (r_table_size > NSLOT_S) begin
            live_size = NSLOT_S;
        end else begin
            live_size = r_table_size;
        end
    end

    assign mod_req.start = accept;
    assign mod_req.key   = i_cmd.key;
    assign mod_req.size  = live_size;

    lpht_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    always_comb begin
        hit = 1'b0;
        if (r_chk_valid) begin
            if (r_cmd == lpht_pkg::CMD_INSERT) begin
                hit = !r_chk_used;
            end else if (r_cmd == lpht_pkg::CMD_DELETE || r_cmd == lpht_pkg::CMD_SEARCH) begin
                hit = r_chk_used && (r_rd == r_key);
            end
        end
    end

    assign issue  = (r_state == S_PROBE) && !hit && (r_issued != r_size);
    assign retire = (r_state == S_DONE) && (!r_out_valid || o_res.ready);
    assign n_pos  = ((8'(r_pos) + 8'd1) == {1'b0, r_size}) ? '0 : r_pos + 1'b1;
    assign res_pos8 = 8'(r_res_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_table_size <= lpht_pkg::SIZE_RESET;
            r_chk_valid  <= 1'b0;
            r_used       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_table_size <= i_cfg_wdata;
            end
            if (o_res.ready && !retire) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_chk_valid <= 1'b0;
                    if (mod_rsp.done) begin
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (hit || r_issued == r_size) begin
                        r_state <= S_DONE;
                    end else begin
                        r_chk_valid <= 1'b1;
                    end
                end
                S_DONE: begin
                    if (retire) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_ok && r_cmd == lpht_pkg::CMD_INSERT) begin
                            r_used[r_res_pos] <= 1'b1;
                        end else if (r_ok && r_cmd == lpht_pkg::CMD_DELETE) begin
                            r_used[r_res_pos] <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_cmd.command;
            r_key  <= i_cmd.key;
            r_size <= live_size;
        end
        if (r_state == S_DIV && mod_rsp.done) begin
            r_pos    <= IW'(mod_rsp.rem);
            r_issued <= '0;
        end
        if (issue) begin
            r_pos      <= n_pos;
            r_issued   <= r_issued + 1'b1;
            r_chk_pos  <= r_pos;
            r_chk_used <= r_used[r_pos];
        end
        if (r_state == S_PROBE) begin
            r_ok      <= hit;
            r_res_pos <= r_chk_pos;
        end
        if (retire) begin
            r_out_status <= !r_ok;
            r_out_slot   <= r_ok ? res_pos8[lpht_pkg::SLOT_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd <= r_mem[r_pos];
        end
        if (retire && r_ok && r_cmd == lpht_pkg::CMD_INSERT) begin
            r_mem[r_res_pos] <= r_key;
        end
    end

    assign i_cmd.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_out_status;
    assign o_res.slot_index = r_out_slot;

endmodule

// File: test/tb_top.sv
// Self-checking bench for the linear probing hash table: directed and random commands.
`timescale 1ns / 100ps

typedef struct {
    logic                        status;
    logic [lpht_pkg::SLOT_W-1:0] slot_index;
} t_slot_reply;

class hash_table_scoreboard;
    logic [lpht_pkg::KEY_W-1:0]  slot_key [lpht_pkg::DEPTH_DEF];
    bit                          slot_used [lpht_pkg::DEPTH_DEF];
    logic [lpht_pkg::SIZE_W-1:0] size_reg;
    t_slot_reply                 replies_due [$];
    int                          errors;

    function new();
        size_reg = lpht_pkg::SIZE_RESET;
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        errors = 0;
    endfunction

    function void set_size(logic [lpht_pkg::SIZE_W-1:0] value);
        size_reg = value;
    endfunction

    function int unsigned live_size();
        if (size_reg == '0) return 1;
        if (size_reg > lpht_pkg::DEPTH_DEF) return lpht_pkg::DEPTH_DEF;
        return size_reg;
    endfunction

    function int pending();
        return replies_due.size();
    endfunction

    // Walk from the home slot, wrapping at the live size, for an empty slot or the key.
    function bit probe(bit want_empty, logic [lpht_pkg::KEY_W-1:0] key,
                       output int unsigned where);
        int unsigned sz;
        int unsigned pos;
        sz = live_size();
        pos = key % sz;
        where = 0;
        for (int unsigned n = 0; n < sz; n++) begin
            if (want_empty ? !slot_used[pos] : (slot_used[pos] && slot_key[pos] == key)) begin
                where = pos;
                return 1'b1;
            end
            pos = (pos + 1 == sz) ? 0 : pos + 1;
        end
        return 1'b0;
    endfunction

    function void note_command(logic [lpht_pkg::CMD_W-1:0] cmd,
                               logic [lpht_pkg::KEY_W-1:0] key);
        t_slot_reply reply;
        int unsigned where;
        bit          hit;
        hit = 1'b0;
        where = 0;
        case (cmd)
            lpht_pkg::CMD_INSERT: begin
                hit = probe(1'b1, key, where);
                if (hit) begin
                    slot_key[where] = key;
                    slot_used[where] = 1'b1;
                end
            end
            lpht_pkg::CMD_DELETE: begin
                hit = probe(1'b0, key, where);
                if (hit) slot_used[where] = 1'b0;
            end
            lpht_pkg::CMD_SEARCH: hit = probe(1'b0, key, where);
            default: hit = 1'b0;
        endcase
        reply.status = !hit;
        reply.slot_index = hit ? lpht_pkg::SLOT_W'(where) : '0;
        replies_due.push_back(reply);
    endfunction

    function void check_result(logic status, logic [lpht_pkg::SLOT_W-1:0] slot_index);
        t_slot_reply want;
        if (replies_due.size() == 0) begin
            $display("%0t: unexpected word, status %0d slot_index %0d",
                     $time, status, slot_index);
            errors++;
            return;
        end
        want = replies_due.pop_front();
        if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            errors++;
        end
        if (slot_index !== want.slot_index) begin
            $display("%0t: slot_index expected %0d actual %0d",
                     $time, want.slot_index, slot_index);
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam logic [lpht_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 90;
    localparam int PHASE_ITEMS = 88;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        cfg_we;
    logic [lpht_pkg::SIZE_W-1:0] cfg_wdata;

    int                          send_idle_pct;
    int                          recv_idle_pct;
    bit                          hold_req;
    logic [lpht_pkg::KEY_W-1:0]  known_keys [$];

    hash_table_scoreboard sb;

    lpht_cmd_if cmd_if ();
    lpht_res_if res_if ();

    linear_probe_hash_table u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #8ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready) sb.note_command(cmd_if.command, cmd_if.key);
            if (res_if.valid && res_if.ready) sb.check_result(res_if.status, res_if.slot_index);
        end
    end

    task automatic send_word(input logic [lpht_pkg::CMD_W-1:0] cmd,
                             input logic [lpht_pkg::KEY_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.command <= cmd;
        cmd_if.key <= key;
        do @(posedge i_clk); while (!cmd_if.ready);
    endtask

    task automatic settle();
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [lpht_pkg::SIZE_W-1:0] value);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.set_size(value);
    endtask

    task automatic run_random(input int count, input bit hold_mid);
        int unsigned                sz;
        int unsigned                pick;
        logic [lpht_pkg::CMD_W-1:0] cmd;
        logic [lpht_pkg::KEY_W-1:0] key;
        for (int i = 0; i < count; i++) begin
            sz = sb.live_size();
            pick = $urandom_range(99);
            if (pick < 40) cmd = lpht_pkg::CMD_INSERT;
            else if (pick < 70) cmd = lpht_pkg::CMD_DELETE;
            else if (pick < 98) cmd = lpht_pkg::CMD_SEARCH;
            else cmd = CMD_NONE;
            // small keys up to 4 * live size + 3, mix in wide keys and repeats
            pick = $urandom_range(99);
            if (pick < 45 || known_keys.size() == 0) begin
                key = lpht_pkg::KEY_W'($urandom_range(4 * sz + 3));
            end else if (pick < 65) begin
                key = lpht_pkg::KEY_W'($urandom);
            end else begin
                key = known_keys[$urandom_range(known_keys.size() - 1)];
            end
            if (cmd == lpht_pkg::CMD_INSERT) begin
                known_keys.push_back(key);
                if (known_keys.size() > 48) void'(known_keys.pop_front());
            end
            if (hold_mid && i == count / 2) hold_req = 1'b1;
            send_word(cmd, key);
        end
    endtask

    initial begin
        sb = new();
        hold_req = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        cmd_if.valid <= 1'b0;
        cmd_if.command <= lpht_pkg::CMD_INSERT;
        cmd_if.key <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_size(lpht_pkg::SIZE_RESET);
        send_word(lpht_pkg::CMD_SEARCH, 31'd0);
        send_word(lpht_pkg::CMD_INSERT, 31'd0);
        send_word(lpht_pkg::CMD_INSERT, 31'd0);
        send_word(lpht_pkg::CMD_INSERT, 31'h7FFF_FFFF);
        send_word(lpht_pkg::CMD_INSERT, 31'd64);
        send_word(lpht_pkg::CMD_INSERT, 31'd127);
        send_word(lpht_pkg::CMD_SEARCH, 31'd127);
        send_word(lpht_pkg::CMD_DELETE, 31'd0);
        send_word(lpht_pkg::CMD_SEARCH, 31'd0);
        send_word(lpht_pkg::CMD_DELETE, 31'd5);
        send_word(CMD_NONE, 31'd0);
        send_word(lpht_pkg::CMD_INSERT, 31'd128);
        send_word(lpht_pkg::CMD_INSERT, 31'h5555_5555);
        send_word(lpht_pkg::CMD_INSERT, 31'h2AAA_AAAA);
        send_word(lpht_pkg::CMD_SEARCH, 31'h2AAA_AAAA);

        write_size(lpht_pkg::SIZE_W'(0));
        send_word(lpht_pkg::CMD_INSERT, 31'd5);
        send_word(lpht_pkg::CMD_SEARCH, 31'd128);
        send_word(lpht_pkg::CMD_DELETE, 31'd128);
        send_word(lpht_pkg::CMD_INSERT, 31'd9);
        send_word(lpht_pkg::CMD_INSERT, 31'd10);

        write_size(lpht_pkg::SIZE_W'(lpht_pkg::SIZE_MAX));
        send_word(lpht_pkg::CMD_SEARCH, 31'h7FFF_FFFF);
        send_word(lpht_pkg::CMD_DELETE, 31'h2AAA_AAAA);

        write_size(lpht_pkg::SIZE_W'(3));
        send_word(lpht_pkg::CMD_SEARCH, 31'd127);
        send_word(lpht_pkg::CMD_SEARCH, 31'd64);
        send_word(lpht_pkg::CMD_INSERT, 31'd3);

        send_idle_pct = 30;
        recv_idle_pct = 46;
        write_size(lpht_pkg::SIZE_W'(64));
        run_random(PHASE_ITEMS, 1'b1);
        write_size(lpht_pkg::SIZE_W'(6));
        run_random(PHASE_ITEMS, 1'b0);
        write_size(lpht_pkg::SIZE_W'(lpht_pkg::SIZE_MAX));
        run_random(PHASE_ITEMS, 1'b0);

        send_idle_pct = 46;
        recv_idle_pct = 30;
        write_size(lpht_pkg::SIZE_W'(1));
        run_random(PHASE_ITEMS, 1'b0);
        write_size(lpht_pkg::SIZE_W'(19));
        run_random(PHASE_ITEMS, 1'b0);
        write_size(lpht_pkg::SIZE_W'(0));
        run_random(PHASE_ITEMS, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_size(lpht_pkg::SIZE_W'(41));
        run_random(PHASE_ITEMS, 1'b1);
        write_size(lpht_pkg::SIZE_W'(64));
        run_random(PHASE_ITEMS, 1'b0);

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
